@@ rtl/core/s2d_pkg.sv @@
// package for the signed integer to decimal ascii converter
// shared constants, sequencer state type and datapath control struct; no dependencies

package s2d_pkg;

    // default width of the signed input
    localparam int VALUE_BITS_DEF = 32;

    // ascii codes, six bits wide as carried on the result port
    localparam logic [5:0] CHAR_ZERO  = 6'd48;
    localparam logic [5:0] CHAR_MINUS = 6'd45;

    // decimal digit value that needs the add-3 correction before a shift
    localparam logic [3:0] DABBLE_LIMIT = 4'd5;
    localparam logic [3:0] DABBLE_ADD   = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGITS
    } s2d_state_t;

    // controls from the sequencer to the shift unit
    typedef struct packed {
        logic load;
        logic shift;
    } s2d_ctrl_t;

endpackage

@@ rtl/core/s2d_dabble.sv @@
// shift and add-3 unit: turns a binary magnitude into packed bcd, one bit per step
// depends on s2d_pkg for the control struct and correction constants

module s2d_dabble #(
    parameter int VALUE_BITS = s2d_pkg::VALUE_BITS_DEF,
    parameter int NUM_DIGITS = 10
) (
    input  logic                              clk,
    input  s2d_pkg::s2d_ctrl_t                ctrl,
    input  logic [VALUE_BITS-1:0]             mag,
    output logic [NUM_DIGITS-1:0][3:0]        digits
);
    import s2d_pkg::*;

    logic [VALUE_BITS-1:0]      mag_reg;
    logic [VALUE_BITS-1:0]      mag_next;
    logic [NUM_DIGITS-1:0][3:0] bcd_reg;
    logic [NUM_DIGITS-1:0][3:0] bcd_next;
    logic [NUM_DIGITS-1:0][3:0] adj;

    // correct every digit that would overflow past nine after doubling
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            adj[i] = (bcd_reg[i] >= DABBLE_LIMIT) ? (bcd_reg[i] + DABBLE_ADD) : bcd_reg[i];
        end
    end

    always_comb
    begin
        mag_next = mag_reg;
        bcd_next = bcd_reg;
        if (ctrl.load)
        begin
            mag_next = mag;
            bcd_next = '0;
        end
        else if (ctrl.shift)
        begin
            mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
            bcd_next[0] = {adj[0][2:0], mag_reg[VALUE_BITS-1]};
            for (int i = 1; i < NUM_DIGITS; i++)
            begin
                bcd_next[i] = {adj[i][2:0], adj[i-1][3]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign digits = bcd_reg;

endmodule

@@ rtl/core/signed_int_to_decimal_ascii.sv @@
// top level of the signed integer to decimal ascii converter
// sequencer, sign handling and character output; uses s2d_pkg and s2d_dabble
//
// usage: drive value and raise start while busy is low; the request is taken at
// that clock edge and busy goes high on the next cycle. the magnitude is formed
// one bit wider in effect (as an unsigned word), so the most negative value
// prints in full. the text leaves one character per strobe, most significant
// first: an optional '-' then the digits with no leading zeros; zero is a single
// '0'. last marks the final character. there is no terminator.
// order: a load, then the shift and add-3 unit takes in one magnitude bit per
// cycle until all VALUE_BITS bits are in, then the sign goes out when negative,
// then each digit position of the bcd register (NUM_DIGITS, 10 at 32 bits) is
// walked in turn, leading zero positions being walked without a strobe. the
// last character shows in the cycle busy drops, so a new request may be taken
// while it is on the ports.
// the receiver cannot stall: each character is valid for exactly one cycle.
// reset clears the sequencer and the strobe; data registers are not reset.

module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = s2d_pkg::VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [VALUE_BITS-1:0] value,
    output logic                         strobe,
    output logic [5:0]                   char_code,
    output logic                         last
);
    import s2d_pkg::*;

    // decimal digits of 2^(VALUE_BITS-1), the largest magnitude
    localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int IDX_W      = $clog2(NUM_DIGITS);

    s2d_state_t              state_reg, state_next;
    logic [CNT_W-1:0]        bit_cnt_reg, bit_cnt_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    neg_reg, neg_next;
    logic                    started_reg, started_next;
    logic                    strobe_reg, strobe_next;
    logic [5:0]              char_reg, char_next;
    logic                    last_reg, last_next;

    s2d_ctrl_t               ctrl;
    logic [VALUE_BITS-1:0]   value_u;
    logic [VALUE_BITS-1:0]   mag;
    logic [NUM_DIGITS-1:0][3:0] digits;
    logic [3:0]              cur_digit;
    logic                    accept;

    // magnitude as unsigned: the most negative value maps to 2^(VALUE_BITS-1)
    assign value_u = value;
    assign mag     = value_u[VALUE_BITS-1] ? (~value_u + VALUE_BITS'(1)) : value_u;
    assign accept  = start && (state_reg == ST_IDLE);

    s2d_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dabble (
        .clk    (clk),
        .ctrl   (ctrl),
        .mag    (mag),
        .digits (digits)
    );

    assign cur_digit = digits[idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_cnt_reg <= bit_cnt_next;
        idx_reg     <= idx_next;
        neg_reg     <= neg_next;
        started_reg <= started_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        idx_next     = idx_reg;
        neg_next     = neg_reg;
        started_next = started_reg;
        strobe_next  = 1'b0;
        char_next    = char_reg;
        last_next    = last_reg;
        ctrl         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctrl.load    = 1'b1;
                    neg_next     = value_u[VALUE_BITS-1];
                    bit_cnt_next = CNT_W'(VALUE_BITS - 1);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                // one magnitude bit into the bcd register per cycle
                ctrl.shift   = 1'b1;
                bit_cnt_next = bit_cnt_reg - CNT_W'(1);
                if (bit_cnt_reg == '0)
                begin
                    idx_next     = IDX_W'(NUM_DIGITS - 1);
                    started_next = 1'b0;
                    state_next   = neg_reg ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN:
            begin
                strobe_next = 1'b1;
                char_next   = CHAR_MINUS;
                last_next   = 1'b0;
                state_next  = ST_DIGITS;
            end
            ST_DIGITS:
            begin
                // leading zeros are skipped, the units digit always shows
                if (started_reg || (cur_digit != 4'd0) || (idx_reg == '0))
                begin
                    strobe_next  = 1'b1;
                    started_next = 1'b1;
                    char_next    = CHAR_ZERO + {2'b00, cur_digit};
                    last_next    = (idx_reg == '0);
                end
                idx_next = idx_reg - IDX_W'(1);
                if (idx_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != ST_IDLE);
    assign strobe    = strobe_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    // a taken request always starts the conversion
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request taken but block not busy");

    // every character is a minus sign or a decimal digit
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (char_code == CHAR_MINUS) ||
                   ((char_code >= CHAR_ZERO) && (char_code <= CHAR_ZERO + 6'd9)))
        else $error("character outside minus and digits");

    // the sign is never the final character
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (char_code == CHAR_MINUS) |-> !last)
        else $error("minus sign marked last");

    // no character follows the final one in the next cycle
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("character right after final one");
`endif

endmodule
